### design/png_scanline_unfilter_defines.svh
// Assertion macros shared by the scanline unfilter modules.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psu_pkg.sv
// Types, constants and helper functions of the scanline unfilter.
package psu_pkg;

  localparam int MAX_ROW_BYTES = 16384;
  localparam int ROW_AW        = $clog2(MAX_ROW_BYTES);
  localparam int COL_W         = ROW_AW + 1;
  localparam int MAX_CHANNELS  = 4;
  localparam int CH_W          = $clog2(MAX_CHANNELS);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_BPP       = 1'b0,
    REG_ROW_BYTES = 1'b1
  } cfg_reg_t;

  // Filter types of a row
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // One item handed from the column control to the reconstruction stage
  typedef struct packed {
    logic              bad;
    logic [7:0]        sample;
    logic [ROW_AW-1:0] pos;
    logic [ROW_AW-1:0] dest;
    logic [CH_W-1:0]   ch;
    filt_t             filt;
    logic              first;
    logic              done;
  } psu_item_t;

  // Control group from the column control to the reconstruction stage
  typedef struct packed {
    logic      load;
    logic      clear;
    psu_item_t item;
  } psu_issue_t;

  // RGB to BGR swap offset, two's complement on the row address width
  function automatic logic [ROW_AW-1:0] swap_off(input logic rgba, input logic [CH_W-1:0] ch);
    logic [ROW_AW-1:0] off;
    begin
      off = '0;
      if (ch == CH_W'(0)) begin
        off = ROW_AW'(2);
      end else if (ch == CH_W'(2)) begin
        off = -ROW_AW'(2);
      end
      if (!rgba && ch == CH_W'(3)) begin
        off = '0;
      end
      return off;
    end
  endfunction

  // Paeth predictor on 8-bit samples
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    logic [7:0]         res;
    begin
      da  = $signed({3'b000, b}) - $signed({3'b000, c});
      db  = $signed({3'b000, a}) - $signed({3'b000, c});
      dc  = da + db;
      pa  = da[10] ? 10'(-da) : da[9:0];
      pb  = db[10] ? 10'(-db) : db[9:0];
      pc  = dc[10] ? 10'(-dc) : dc[9:0];
      if (pa <= pb && pa <= pc) begin
        res = a;
      end else if (pb <= pc) begin
        res = b;
      end else begin
        res = c;
      end
      return res;
    end
  endfunction

endpackage

### design/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter for 8-bit RGB and RGBA rows.
// Sustains one input byte per clock while the output is not stalled. A data
// byte passes through the stage-one register and the output register; the
// filter byte at a row start gives no result. The rate is set by the single
// row store (16384 x 8), which is read once and written once per cycle: the
// upper byte is read when a byte is accepted and the rebuilt byte is written
// back when it moves to the output register. The row store is not cleared
// after reset; the first row ignores the bytes read from it.
// An unknown filter type gives one result with tuser set and locks the block
// until reset, dropping every later byte.
module png_scanline_unfilter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  psu_pkg::cfg_reg_t cfg_index,
  input  logic [14:0]       cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] filtered_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [7:0] pixel_byte, [21:8] dest_index, zero pad
  output logic              out_tlast,  // row_done
  output logic [0:0]        out_tuser   // [0] bad_filter
);
  import psu_pkg::*;

  psu_issue_t        issue;
  logic              take_ok;
  logic [7:0]        pixel;
  logic [ROW_AW-1:0] dest;
  logic              bad;

  psu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_sample (in_tdata),
    .take_ok   (take_ok),
    .in_tready (in_tready),
    .issue     (issue)
  );

  psu_recon u_recon (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .take_ok   (take_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (pixel),
    .out_dest  (dest),
    .out_last  (out_tlast),
    .out_bad   (bad)
  );

  // Pack the result transaction
  assign out_tdata = {2'b00, dest, pixel};
  assign out_tuser = bad;

endmodule

### design/psu_ctrl.sv
// Column, channel and filter control with the configuration registers.
`include "png_scanline_unfilter_defines.svh"

module psu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  psu_pkg::cfg_reg_t cfg_index,
  input  logic [14:0]       cfg_data,
  input  logic              in_tvalid,
  input  logic [7:0]        in_sample,
  input  logic              take_ok,
  output logic              in_tready,
  output psu_pkg::psu_issue_t issue
);
  import psu_pkg::*;

  logic [2:0]       bpp_cfg_r;
  logic [14:0]      row_bytes_r;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [CH_W-1:0]  channel_r, channel_nxt;
  filt_t            filt_r, filt_nxt;
  logic             first_row_r, first_row_nxt;
  logic             error_r, error_nxt;

  logic             rgba;
  logic [COL_W-1:0] len;
  logic [CH_W-1:0]  ch;
  logic             accept;
  logic             done;
  logic [ROW_AW-1:0] pos;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_cfg_r   <= 3'd3;
      row_bytes_r <= 15'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BPP:       bpp_cfg_r   <= cfg_data[2:0];
        REG_ROW_BYTES: row_bytes_r <= cfg_data;
      endcase
    end
  end

  // Effective pixel size and clamped row length
  assign rgba = (bpp_cfg_r == 3'd4);

  always_comb begin
    if (row_bytes_r == 15'd0) begin
      len = COL_W'(1);
    end else if (COL_W'(row_bytes_r) > COL_W'(MAX_ROW_BYTES)) begin
      len = COL_W'(MAX_ROW_BYTES);
    end else begin
      len = COL_W'(row_bytes_r);
    end
  end

  assign in_tready = take_ok;
  assign accept    = in_tvalid && take_ok;
  assign ch        = (!rgba && channel_r == CH_W'(3)) ? '0 : channel_r;
  assign pos       = ROW_AW'(column_r - COL_W'(1));
  assign done      = (column_r >= len);

  // Decode the accepted byte and advance the row position
  always_comb begin
    column_nxt    = column_r;
    channel_nxt   = channel_r;
    filt_nxt      = filt_r;
    first_row_nxt = first_row_r;
    error_nxt     = error_r;
    issue         = '0;
    issue.item.sample = in_sample;
    issue.item.pos    = pos;
    issue.item.dest   = pos + swap_off(rgba, ch);
    issue.item.ch     = ch;
    issue.item.filt   = filt_r;
    issue.item.first  = first_row_r;
    issue.item.done   = done;
    if (accept && !error_r) begin
      if (column_r == '0) begin
        if (in_sample > 8'd4) begin
          error_nxt      = 1'b1;
          issue.load     = 1'b1;
          issue.item.bad = 1'b1;
        end else begin
          filt_nxt    = filt_t'(in_sample[2:0]);
          issue.clear = 1'b1;
          channel_nxt = '0;
          column_nxt  = COL_W'(1);
        end
      end else begin
        issue.load = 1'b1;
        if (done) begin
          column_nxt    = '0;
          first_row_nxt = 1'b0;
          channel_nxt   = '0;
        end else begin
          column_nxt  = column_r + COL_W'(1);
          channel_nxt = (rgba ? (ch == CH_W'(3)) : (ch == CH_W'(2))) ? '0 : ch + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      channel_r   <= '0;
      filt_r      <= FILT_NONE;
      first_row_r <= 1'b1;
      error_r     <= 1'b0;
    end else begin
      column_r    <= column_nxt;
      channel_r   <= channel_nxt;
      filt_r      <= filt_nxt;
      first_row_r <= first_row_nxt;
      error_r     <= error_nxt;
    end
  end

  `PSU_ASSERT_NOW(a_no_issue_after_error, error_r, !issue.load && !issue.clear,
                  "item issued after a bad filter")
  `PSU_ASSERT_NOW(a_column_in_range, 1'b1, column_r <= COL_W'(MAX_ROW_BYTES),
                  "column beyond the row store")
  `PSU_ASSERT_NEXT(a_error_sticky, error_r, error_r, "error flag cleared without reset")

endmodule

### design/psu_recon.sv
// Row store, sample reconstruction and output register.
`include "png_scanline_unfilter_defines.svh"

module psu_recon (
  input  logic                clk,
  input  logic                rst_n,
  input  psu_pkg::psu_issue_t issue,
  output logic                take_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_pixel,
  output logic [psu_pkg::ROW_AW-1:0] out_dest,
  output logic                out_last,
  output logic                out_bad
);
  import psu_pkg::*;

  logic [7:0] row_mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;

  psu_item_t  s1_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_move;
  logic       rd_en;
  logic       wr_en;

  logic [7:0] left_r [MAX_CHANNELS];
  logic [7:0] ul_r   [MAX_CHANNELS];
  logic [7:0] a, b, c, pred, val;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] pix_r;
  logic [ROW_AW-1:0] dest_r;
  logic       last_r;
  logic       bad_r;

  // Advance stage one when the output register is free or being emptied
  assign s1_move = s1_valid_r && (!out_valid_r || out_ready);
  assign take_ok = !s1_valid_r || s1_move;
  assign rd_en   = issue.load && !issue.item.bad;
  assign wr_en   = s1_move && !s1_r.bad;

  // Row store: read the upper byte on issue, write back the rebuilt byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= row_mem[issue.item.pos];
    end
    if (wr_en) begin
      row_mem[s1_r.pos] <= val;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue.load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.load) begin
      s1_r <= issue.item;
    end
  end

  // Predict from left, upper and upper-left bytes of the channel
  assign a = left_r[s1_r.ch];
  assign b = s1_r.first ? 8'd0 : rd_data_r;
  assign c = ul_r[s1_r.ch];

  always_comb begin
    unique case (s1_r.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign val = s1_r.sample + pred;

  // Update the per-channel history; a row start clears it afterwards
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_r[i] <= 8'd0;
        ul_r[i]   <= 8'd0;
      end
    end else if (issue.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_r[i] <= 8'd0;
        ul_r[i]   <= 8'd0;
      end
    end else if (wr_en) begin
      left_r[s1_r.ch] <= val;
      ul_r[s1_r.ch]   <= b;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pix_r  <= s1_r.bad ? 8'd0 : val;
      dest_r <= s1_r.bad ? '0 : s1_r.dest;
      last_r <= s1_r.bad ? 1'b0 : s1_r.done;
      bad_r  <= s1_r.bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pix_r;
  assign out_dest  = dest_r;
  assign out_last  = last_r;
  assign out_bad   = bad_r;

  `PSU_ASSERT_NOW(a_no_same_entry, rd_en && wr_en, issue.item.pos != s1_r.pos,
                  "row store read and write hit the same entry")
  `PSU_ASSERT_NOW(a_bad_result_empty, out_valid_r && bad_r,
                  pix_r == 8'd0 && dest_r == '0 && !last_r,
                  "bad filter result carries payload")
  `PSU_ASSERT_NEXT(a_stage_holds, s1_valid_r && out_valid_r && !out_ready,
                   s1_valid_r, "stage one lost an item while stalled")

endmodule
